// ===== rtl/lgh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, field widths and elaboration-time helpers for the logistic
// gradient/hessian unit. No dependencies.
package lgh_pkg;

    localparam int SCORE_W  = 32;
    localparam int LABEL_W  = 17;
    localparam int WEIGHT_W = 24;
    localparam int GRAD_W   = 25;
    localparam int HESS_W   = 24;
    localparam int MINH_W   = 16;

    // Saturation limit of both result fields
    localparam logic [HESS_W-1:0] OUT_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [LABEL_W-1:0]        label;
        logic [WEIGHT_W-1:0]       weight;
        logic                      is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gradient;
        logic [HESS_W-1:0]        hessian;
        logic                     last_out;
    } out_item_t;

    // Fields that ride alongside the sigmoid pipeline
    typedef struct packed {
        logic [LABEL_W-1:0]  label;
        logic [WEIGHT_W-1:0] weight;
        logic                is_last;
    } side_t;

    // Restoring division over the low nbits of num; used only to build the
    // sigmoid table at elaboration.
    function automatic logic [63:0] udiv(input logic [63:0] num,
                                         input logic [63:0] den,
                                         input int unsigned nbits);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            if (i < nbits) begin
                rem = {rem[62:0], num[i]};
                if (rem >= den) begin
                    rem    = rem - den;
                    quo[i] = 1'b1;
                end
            end
        end
        return quo;
    endfunction

    // exp(-f / 2^32) in Q32, 24-term alternating series
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        pos  = 64'd1 << 32;
        neg  = '0;
        term = 64'd1 << 32;
        for (int n = 1; n <= 24; n++) begin
            term = udiv((term * f) >> 32, 64'(n), 32);
            if ((n & 1) != 0) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return pos - neg;
    endfunction

    // exp(-1) in Q32 as the square of exp(-1/2)
    function automatic logic [63:0] exp_neg_one();
        logic [63:0] half;
        half = exp_neg_frac(64'h8000_0000);
        return (half * half) >> 32;
    endfunction

    // Table point idx: sigmoid(16*idx/entries) in Q1.frac, rounded
    function automatic logic [63:0] sig_entry(input int unsigned idx,
                                              input int unsigned entries,
                                              input int unsigned frac,
                                              input logic [63:0] e1);
        logic [63:0] x;
        logic [63:0] k;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        x = udiv(64'(idx) << 36, 64'(entries), 64);
        k = x >> 32;
        e = exp_neg_frac(x & 64'hFFFF_FFFF);
        for (int j = 0; j < 16; j++) begin
            if (64'(j) < k) begin
                e = (e * e1) >> 32;
            end
        end
        den = (64'd1 << 32) + e;
        num = ((64'd1 << frac) << 32) + (den >> 1);
        return udiv(num, den, 64);
    endfunction

endpackage

// ===== rtl/lgh_sigmoid.sv =====
`timescale 1ns / 1ps
// Four-stage sigmoid pipeline: index split, table read, interpolation
// product, sign fold. Depends on lgh_pkg.
module lgh_sigmoid #(
    parameter int SIGMOID_TABLE_ENTRIES = 1024,
    parameter int FRAC_BITS             = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [lgh_pkg::SCORE_W-1:0] score,
    input  lgh_pkg::side_t                 in_side,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [FRAC_BITS:0]             p,
    output lgh_pkg::side_t                 out_side
);

    localparam int PW  = FRAC_BITS + 1;
    localparam int SEG = FRAC_BITS + 4;
    localparam int IW  = $clog2(SIGMOID_TABLE_ENTRIES);
    localparam int AW  = $clog2(SIGMOID_TABLE_ENTRIES + 1);
    localparam int PSW = SEG + AW;
    localparam int MW  = PW + SEG;
    localparam logic [PW-1:0] ONE     = PW'(1) << FRAC_BITS;
    localparam logic [31:0]   SAT_LIM = 32'(16) << FRAC_BITS;
    localparam logic [63:0]   E1      = lgh_pkg::exp_neg_one();

    // Sigmoid table, entries+1 points
    logic [PW-1:0] rom [0:SIGMOID_TABLE_ENTRIES];

    for (genvar g = 0; g <= SIGMOID_TABLE_ENTRIES; g++) begin : g_rom
        localparam logic [63:0] ENTRY = lgh_pkg::sig_entry(32'(g),
            32'(SIGMOID_TABLE_ENTRIES), 32'(FRAC_BITS), E1);
        assign rom[g] = ENTRY[PW-1:0];
    end

    // Stage registers
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 neg1_reg, neg2_reg, neg3_reg;
    logic                 sat1_reg, sat2_reg, sat3_reg;
    logic [IW-1:0]        idx1_reg;
    logic [SEG-1:0]       fr1_reg, fr2_reg;
    logic [PW-1:0]        lo2_reg, hi2_reg, lo3_reg, interp3_reg, p4_reg;
    lgh_pkg::side_t       side1_reg, side2_reg, side3_reg, side4_reg;

    logic en1, en2, en3, en4;

    // A stage loads when it is empty or its content moves on
    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Stage 1: magnitude, saturation, table index and fraction
    logic [31:0]    score_bits;
    logic [31:0]    abs_score;
    logic           neg1_next;
    logic           sat1_next;
    logic [PSW-1:0] pos;
    logic [IW-1:0]  idx1_next;
    logic [SEG-1:0] fr1_next;

    always_comb begin
        score_bits = $unsigned(score);
        neg1_next  = score_bits[31];
        abs_score  = neg1_next ? (~score_bits + 32'd1) : score_bits;
        sat1_next  = abs_score >= SAT_LIM;
        pos        = PSW'(abs_score[SEG-1:0]) * PSW'(SIGMOID_TABLE_ENTRIES);
        idx1_next  = pos[SEG +: IW];
        fr1_next   = pos[SEG-1:0];
    end

    // Stage 3: interpolation product on the segment slope
    logic [PW-1:0] diff;
    logic [MW-1:0] prod;
    logic [PW-1:0] interp3_next;

    always_comb begin
        diff         = (hi2_reg < lo2_reg) ? '0 : (hi2_reg - lo2_reg);
        prod         = MW'(diff) * MW'(fr2_reg);
        interp3_next = prod[SEG +: PW];
    end

    // Stage 4: add, clamp, saturate, mirror for negative scores
    logic [PW:0]   sum;
    logic [PW-1:0] p_mag;
    logic [PW-1:0] p4_next;

    always_comb begin
        sum = {1'b0, lo3_reg} + {1'b0, interp3_reg};
        if (sat3_reg) begin
            p_mag = ONE;
        end else if (sum > {1'b0, ONE}) begin
            p_mag = ONE;
        end else begin
            p_mag = sum[PW-1:0];
        end
        p4_next = neg3_reg ? (ONE - p_mag) : p_mag;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Payload; stage 2 is the registered two-port table read
    always_ff @(posedge aclk) begin
        if (en1) begin
            neg1_reg  <= neg1_next;
            sat1_reg  <= sat1_next;
            idx1_reg  <= idx1_next;
            fr1_reg   <= fr1_next;
            side1_reg <= in_side;
        end
        if (en2) begin
            lo2_reg   <= rom[AW'(idx1_reg)];
            hi2_reg   <= rom[AW'(idx1_reg) + AW'(1)];
            neg2_reg  <= neg1_reg;
            sat2_reg  <= sat1_reg;
            fr2_reg   <= fr1_reg;
            side2_reg <= side1_reg;
        end
        if (en3) begin
            lo3_reg     <= lo2_reg;
            interp3_reg <= interp3_next;
            neg3_reg    <= neg2_reg;
            sat3_reg    <= sat2_reg;
            side3_reg   <= side2_reg;
        end
        if (en4) begin
            p4_reg    <= p4_next;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign p         = p4_reg;
    assign out_side  = side4_reg;

    // Table must be nondecreasing between neighbors
    a_rom_order: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> lo2_reg <= hi2_reg)
        else $error("sigmoid table point above its successor");

    // Probability never exceeds one
    a_p_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> p4_reg <= ONE)
        else $error("sigmoid result above one");

    // A blocked result stays put
    a_p_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !out_ready |=> v4_reg && $stable(p4_reg))
        else $error("sigmoid result changed while blocked");

endmodule

// ===== rtl/lgh_grad_hess.sv =====
`timescale 1ns / 1ps
// Four-stage gradient and hessian pipeline from a probability, the label,
// the weight and the hessian floor. Depends on lgh_pkg.
module lgh_grad_hess #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [FRAC_BITS:0]            p,
    input  lgh_pkg::side_t                in_side,
    input  logic [lgh_pkg::MINH_W-1:0]    min_hessian,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lgh_pkg::out_item_t            out_item
);

    localparam int PW = FRAC_BITS + 1;
    localparam int VW = (PW > lgh_pkg::LABEL_W) ? PW : lgh_pkg::LABEL_W;
    localparam int QW = (PW > lgh_pkg::MINH_W) ? PW : lgh_pkg::MINH_W;
    localparam int GW = lgh_pkg::WEIGHT_W + PW - FRAC_BITS;
    localparam int HW = lgh_pkg::WEIGHT_W + QW - FRAC_BITS;
    localparam int GPW = lgh_pkg::WEIGHT_W + PW;
    localparam int QPW = 2 * PW;
    localparam int HPW = lgh_pkg::WEIGHT_W + QW;
    localparam logic [PW-1:0] ONE  = PW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] QMAX = ONE >> 2;

    logic                          vA_reg, vB_reg, vC_reg, vD_reg;
    logic [PW-1:0]                 pA_reg, ompA_reg, magA_reg, qB_reg;
    logic                          gnegA_reg, gnegB_reg;
    logic [lgh_pkg::WEIGHT_W-1:0]  wA_reg, wB_reg, wC_reg;
    logic                          lastA_reg, lastB_reg, lastC_reg;
    logic [GW-1:0]                 gmB_reg;
    logic signed [lgh_pkg::GRAD_W-1:0] gC_reg;
    logic [QW-1:0]                 qfC_reg;
    lgh_pkg::out_item_t            out_reg;

    logic enA, enB, enC, enD;

    assign enD      = !vD_reg || out_ready;
    assign enC      = !vC_reg || enD;
    assign enB      = !vB_reg || enC;
    assign enA      = !vA_reg || enB;
    assign in_ready = enA;

    // Stage A: label clamp, signed difference, one minus p
    logic [VW-1:0] lbl_ext;
    logic [VW-1:0] lbl_cv;
    logic [PW-1:0] lbl_c;
    logic          gnegA_next;
    logic [PW-1:0] magA_next;
    logic [PW-1:0] ompA_next;

    always_comb begin
        lbl_ext    = VW'(in_side.label);
        lbl_cv     = (lbl_ext > VW'(ONE)) ? VW'(ONE) : lbl_ext;
        lbl_c      = lbl_cv[PW-1:0];
        gnegA_next = p < lbl_c;
        magA_next  = gnegA_next ? (lbl_c - p) : (p - lbl_c);
        ompA_next  = ONE - p;
    end

    // Stage B: weighted gradient magnitude and p*(1-p)
    logic [GPW-1:0] gprod;
    logic [QPW-1:0] qprod;
    logic [GW-1:0]  gmB_next;
    logic [PW-1:0]  qB_next;

    always_comb begin
        gprod    = GPW'(wA_reg) * GPW'(magA_reg);
        qprod    = QPW'(pA_reg) * QPW'(ompA_reg);
        gmB_next = gprod[FRAC_BITS +: GW];
        qB_next  = qprod[FRAC_BITS +: PW];
    end

    // Stage C: hessian floor, gradient clamp and sign
    logic [QW-1:0]                     qfC_next;
    logic [lgh_pkg::HESS_W-1:0]        gsat;
    logic [lgh_pkg::GRAD_W-1:0]        gmag;
    logic signed [lgh_pkg::GRAD_W-1:0] gC_next;

    always_comb begin
        qfC_next = (QW'(qB_reg) < QW'(min_hessian)) ? QW'(min_hessian) : QW'(qB_reg);
        gsat     = (gmB_reg > GW'(lgh_pkg::OUT_MAX)) ? lgh_pkg::OUT_MAX
                                                     : gmB_reg[lgh_pkg::HESS_W-1:0];
        gmag     = {1'b0, gsat};
        gC_next  = gnegB_reg ? $signed(-gmag) : $signed(gmag);
    end

    // Stage D: weighted hessian and clamp
    logic [HPW-1:0]             hprod;
    logic [HW-1:0]              hs;
    lgh_pkg::out_item_t         out_next;

    always_comb begin
        hprod             = HPW'(wC_reg) * HPW'(qfC_reg);
        hs                = hprod[FRAC_BITS +: HW];
        out_next.gradient = gC_reg;
        out_next.hessian  = (hs > HW'(lgh_pkg::OUT_MAX)) ? lgh_pkg::OUT_MAX
                                                         : hs[lgh_pkg::HESS_W-1:0];
        out_next.last_out = lastC_reg;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vA_reg <= 1'b0;
            vB_reg <= 1'b0;
            vC_reg <= 1'b0;
            vD_reg <= 1'b0;
        end else begin
            if (enA) vA_reg <= in_valid;
            if (enB) vB_reg <= vA_reg;
            if (enC) vC_reg <= vB_reg;
            if (enD) vD_reg <= vC_reg;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (enA) begin
            pA_reg    <= p;
            ompA_reg  <= ompA_next;
            magA_reg  <= magA_next;
            gnegA_reg <= gnegA_next;
            wA_reg    <= in_side.weight;
            lastA_reg <= in_side.is_last;
        end
        if (enB) begin
            gmB_reg   <= gmB_next;
            qB_reg    <= qB_next;
            gnegB_reg <= gnegA_reg;
            wB_reg    <= wA_reg;
            lastB_reg <= lastA_reg;
        end
        if (enC) begin
            gC_reg    <= gC_next;
            qfC_reg   <= qfC_next;
            wC_reg    <= wB_reg;
            lastC_reg <= lastB_reg;
        end
        if (enD) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = vD_reg;
    assign out_item  = out_reg;

    // p*(1-p) peaks at one quarter
    a_q_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        vB_reg |-> qB_reg <= QMAX)
        else $error("p*(1-p) above one quarter");

    // Floor applied before weighting
    a_q_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        vC_reg |-> qfC_reg >= QW'(min_hessian))
        else $error("hessian term below floor");

    // A blocked result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vD_reg && !out_ready |=> vD_reg && $stable(out_reg))
        else $error("result changed while blocked");

endmodule

// ===== rtl/logistic_gradient_hessian_unit.sv =====
`timescale 1ns / 1ps
// Top level of the logistic loss gradient/hessian unit: hessian floor
// register, sigmoid pipeline and gradient/hessian pipeline. Depends on lgh_pkg.
//
//  channel   direction  signals                     payload
//  s_        in         s_valid / s_ready           lgh_pkg::in_item_t
//  m_        out        m_valid / m_ready           lgh_pkg::out_item_t
//  cfg_      in         cfg_we (no wait)            min_hessian, 16 bit
//
// One transaction per cycle sustained while m_ready stays high; m_valid rises after the
// accepting edge has passed through 8 register stages (4 sigmoid, 4 arithmetic),
// the second of which is the two-port registered read of the sigmoid table.
// Reset clears all valid bits and sets min_hessian to 0; the table is constant.
// While m_ready is low the result holds; earlier stages keep closing gaps and
// s_ready drops only once all 8 stages hold a transaction.
module logistic_gradient_hessian_unit #(
    parameter int SIGMOID_TABLE_ENTRIES = 1024,
    parameter int FRAC_BITS             = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lgh_pkg::in_item_t           s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lgh_pkg::out_item_t          m_item,
    input  logic                        cfg_we,
    input  logic [lgh_pkg::MINH_W-1:0]  cfg_wdata
);

    logic [lgh_pkg::MINH_W-1:0] min_hessian_reg;

    // Hessian floor register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_hessian_reg <= '0;
        end else if (cfg_we) begin
            min_hessian_reg <= cfg_wdata;
        end
    end

    lgh_pkg::side_t       in_side;
    lgh_pkg::side_t       sig_side;
    logic                 sig_valid;
    logic                 sig_ready;
    logic [FRAC_BITS:0]   sig_p;

    assign in_side.label   = s_item.label;
    assign in_side.weight  = s_item.weight;
    assign in_side.is_last = s_item.is_last;

    lgh_sigmoid #(
        .SIGMOID_TABLE_ENTRIES (SIGMOID_TABLE_ENTRIES),
        .FRAC_BITS             (FRAC_BITS)
    ) u_sigmoid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .score     (s_item.score),
        .in_side   (in_side),
        .out_valid (sig_valid),
        .out_ready (sig_ready),
        .p         (sig_p),
        .out_side  (sig_side)
    );

    lgh_grad_hess #(
        .FRAC_BITS (FRAC_BITS)
    ) u_grad_hess (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (sig_valid),
        .in_ready    (sig_ready),
        .p           (sig_p),
        .in_side     (sig_side),
        .min_hessian (min_hessian_reg),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_item    (m_item)
    );

endmodule

// ===== verif/logistic_gradient_hessian_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for logistic_gradient_hessian_unit: a queue-fed driver, a
// monitor and a bit-exact sigmoid/gradient/hessian predictor with its own table.
// Depends on lgh_pkg and the unit under test.
module logistic_gradient_hessian_unit_tb;

    localparam int LUT_ENTRIES = 1024;
    localparam int FRAC        = 16;
    localparam longint unsigned ONE_Q16 = 64'd1 << FRAC;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASES = 5;
    localparam int ITEMS_PER_PHASE = 216;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    lgh_pkg::in_item_t           s_item    = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    lgh_pkg::out_item_t          m_item;
    logic                        cfg_we    = 1'b0;
    logic [lgh_pkg::MINH_W-1:0]  cfg_wdata = '0;

    // Testbench state
    longint unsigned             sig_lut [0:LUT_ENTRIES];
    logic [lgh_pkg::MINH_W-1:0]  min_hess_floor = '0;
    lgh_pkg::in_item_t           pending_items [$];
    lgh_pkg::out_item_t          grad_hess_q [$];
    logic                        s_fire = 1'b0;
    int unsigned                 send_gap_pct = 0;
    int unsigned                 recv_stall_pct = 0;
    int                          errors = 0;

    logistic_gradient_hessian_unit #(
        .SIGMOID_TABLE_ENTRIES(LUT_ENTRIES),
        .FRAC_BITS(FRAC)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // exp(-f/2^32) in Q32, alternating series of 24 terms
    function automatic longint unsigned exp_neg_q32(longint unsigned f);
        longint unsigned acc_pos;
        longint unsigned acc_neg;
        longint unsigned term;
        acc_pos = 64'd1 << 32;
        acc_neg = 0;
        term    = 64'd1 << 32;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * f) >> 32) / 64'(n);
            if (n % 2 == 1) begin
                acc_neg += term;
            end else begin
                acc_pos += term;
            end
        end
        return acc_pos - acc_neg;
    endfunction

    // Interpolated sigmoid of a Q15.16 score, result in Q1.16
    function automatic longint unsigned sigmoid_q16(logic [31:0] sc);
        logic [31:0]     abs_sc;
        longint unsigned mag;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned fr;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned p;
        abs_sc = sc[31] ? -sc : sc;
        mag    = 64'(abs_sc);
        if (mag >= (64'd16 << FRAC)) begin
            p = ONE_Q16;
        end else begin
            pos = mag * LUT_ENTRIES;
            idx = pos >> (FRAC + 4);
            fr  = pos & ((64'd1 << (FRAC + 4)) - 1);
            if (idx >= LUT_ENTRIES) begin
                idx = LUT_ENTRIES - 1;
            end
            lo = sig_lut[idx];
            hi = sig_lut[idx + 1];
            if (hi < lo) begin
                hi = lo;
            end
            p = lo + (((hi - lo) * fr) >> (FRAC + 4));
            if (p > ONE_Q16) begin
                p = ONE_Q16;
            end
        end
        return sc[31] ? ONE_Q16 - p : p;
    endfunction

    // Expected gradient/hessian for one input transaction
    function automatic lgh_pkg::out_item_t predict_grad_hess(
        lgh_pkg::in_item_t it, logic [lgh_pkg::MINH_W-1:0] floor_q);
        longint unsigned    p;
        longint unsigned    lbl;
        longint unsigned    w;
        longint unsigned    mag;
        longint unsigned    q;
        longint unsigned    h;
        logic               gneg;
        lgh_pkg::out_item_t r;
        p   = sigmoid_q16(it.score);
        lbl = 64'(it.label);
        if (lbl > ONE_Q16) begin
            lbl = ONE_Q16;
        end
        w    = 64'(it.weight);
        gneg = p < lbl;
        mag  = gneg ? lbl - p : p - lbl;
        mag  = (w * mag) >> FRAC;
        if (mag > 64'(lgh_pkg::OUT_MAX)) begin
            mag = 64'(lgh_pkg::OUT_MAX);
        end
        mag = gneg ? -mag : mag;
        q   = (p * (ONE_Q16 - p)) >> FRAC;
        if (q < 64'(floor_q)) begin
            q = 64'(floor_q);
        end
        h = (w * q) >> FRAC;
        if (h > 64'(lgh_pkg::OUT_MAX)) begin
            h = 64'(lgh_pkg::OUT_MAX);
        end
        r.gradient = mag[lgh_pkg::GRAD_W-1:0];
        r.hessian  = h[lgh_pkg::HESS_W-1:0];
        r.last_out = it.is_last;
        return r;
    endfunction

    task automatic queue_item(logic [31:0] sc, logic [lgh_pkg::LABEL_W-1:0] lb,
                              logic [lgh_pkg::WEIGHT_W-1:0] wt, logic lst);
        lgh_pkg::in_item_t it;
        it.score   = sc;
        it.label   = lb;
        it.weight  = wt;
        it.is_last = lst;
        pending_items.push_back(it);
    endtask

    // Sender holds off until every queued transaction has produced its result
    task automatic wait_all_results();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || grad_hess_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_min_hess(logic [lgh_pkg::MINH_W-1:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        min_hess_floor = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Driver: new transaction or idle at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_fire) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_item  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Monitor: record accepted inputs, check accepted results
    always @(posedge aclk) begin : monitor
        lgh_pkg::out_item_t want;
        s_fire <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                grad_hess_q.push_back(predict_grad_hess(s_item, min_hess_floor));
            end
            if (m_valid && m_ready) begin
                if (grad_hess_q.size() == 0) begin
                    $error("result transaction with nothing expected: %h", m_item);
                    errors++;
                end else begin
                    want = grad_hess_q.pop_front();
                    if (m_item.gradient !== want.gradient) begin
                        $error("gradient: expected %0d, got %0d", want.gradient, m_item.gradient);
                        errors++;
                    end
                    if (m_item.hessian !== want.hessian) begin
                        $error("hessian: expected %0d, got %0d", want.hessian, m_item.hessian);
                        errors++;
                    end
                    if (m_item.last_out !== want.last_out) begin
                        $error("last_out: expected %0b, got %0b", want.last_out, m_item.last_out);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles without any handshake
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("logistic_gradient_hessian_unit_tb: done, errors");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        longint unsigned half;
        longint unsigned e1;
        longint unsigned x;
        longint unsigned e;
        longint unsigned den;
        int              sc;
        logic [lgh_pkg::LABEL_W-1:0]  lb;
        logic [lgh_pkg::WEIGHT_W-1:0] wt;

        // Sigmoid table: point i is sigmoid(16*i/entries), rounded
        half = exp_neg_q32(64'd1 << 31);
        e1   = (half * half) >> 32;
        for (int i = 0; i <= LUT_ENTRIES; i++) begin
            x = (64'(i) << 36) / LUT_ENTRIES;
            e = exp_neg_q32(x & 64'hFFFF_FFFF);
            for (longint unsigned k = x >> 32; k > 0; k--) begin
                e = (e * e1) >> 32;
            end
            den        = (64'd1 << 32) + e;
            sig_lut[i] = ((ONE_Q16 << 32) + den / 2) / den;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_gap_pct   = 18;
        recv_stall_pct = 54;

        // Directed: saturation, thresholds, table points, label above one, extremes
        queue_item(32'h0000_0000, 17'd0,      24'd65536,   1'b0);
        queue_item(32'h0000_0000, 17'd65536,  24'd65536,   1'b0);
        queue_item(32'h7FFF_FFFF, 17'd0,      24'hFF_FFFF, 1'b0);
        queue_item(32'h8000_0000, 17'd65536,  24'hFF_FFFF, 1'b1);
        queue_item(32'h0010_0000, 17'd65536,  24'd65536,   1'b0);
        queue_item(32'h000F_FFFF, 17'h1_FFFF, 24'd65536,   1'b0);
        queue_item(32'hFFF0_0000, 17'd0,      24'd65536,   1'b0);
        queue_item(32'hFFF0_0001, 17'd0,      24'hFF_FFFF, 1'b1);
        queue_item(32'h0000_0001, 17'd32768,  24'd65536,   1'b0);
        queue_item(32'hFFFF_FFFF, 17'd32768,  24'd65536,   1'b0);
        queue_item(32'h0001_0000, 17'd65537,  24'd12345,   1'b0);
        queue_item(32'hFFFF_0000, 17'd40000,  24'd0,       1'b0);
        queue_item(32'h0000_0400, 17'd0,      24'd65536,   1'b0);
        queue_item(32'h0000_0401, 17'd65536,  24'd65535,   1'b1);
        queue_item(32'hFFFF_FC00, 17'd16384,  24'h80_0000, 1'b0);
        queue_item(32'h0008_0000, 17'd0,      24'hFF_FFFF, 1'b0);
        queue_item(32'h0012_3456, 17'h1_FFFF, 24'h55_AAAA, 1'b0);
        queue_item(32'h4000_0000, 17'd65536,  24'd1,       1'b0);
        queue_item(32'hC000_0000, 17'd0,      24'd3,       1'b1);
        queue_item(32'h0000_0000, 17'd65536,  24'hFF_FFFF, 1'b0);
        wait_all_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            // Idle profile and hessian floor per phase
            if (ph < 2) begin
                send_gap_pct   = 18;
                recv_stall_pct = 54;
            end else if (ph < 4) begin
                send_gap_pct   = 54;
                recv_stall_pct = 18;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            case (ph)
                0: write_min_hess(16'hFFFF);
                1: write_min_hess(16'h0000);
                2: write_min_hess(16'($urandom_range(1, 16383)));
                3: write_min_hess(16'($urandom_range(16384, 65534)));
                default: write_min_hess(16'd0);
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: sc = int'($urandom_range(0, 2097151)) - 1048576;
                    4: sc = int'($urandom_range(0, 1023)) * 1024
                            + int'($urandom_range(0, 2)) - 1;
                    5: sc = 1048576 + int'($urandom_range(0, 4)) - 2;
                    6, 7: sc = int'($urandom);
                    default: sc = int'($urandom_range(0, 4096));
                endcase
                if ($urandom_range(1) == 1) begin
                    sc = -sc;
                end
                case ($urandom_range(9))
                    0, 1, 2, 3: lb = $urandom_range(1) == 1 ? 17'd65536 : 17'd0;
                    4, 5, 6: lb = 17'($urandom_range(0, 65536));
                    7, 8: lb = 17'($urandom_range(0, 131071));
                    default: lb = 17'($urandom_range(65536, 131071));
                endcase
                case ($urandom_range(9))
                    0, 1, 2, 3: wt = 24'd65536;
                    4, 5, 6: wt = 24'($urandom);
                    7, 8: wt = 24'($urandom_range(0, 131072));
                    default: wt = 24'hFF_FFFF - 24'($urandom_range(0, 255));
                endcase
                queue_item(sc, lb, wt, $urandom_range(7) == 0);
                // Hold the sender midway until the pipe is empty
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_all_results();
                end
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("logistic_gradient_hessian_unit_tb: done, clean");
        end else begin
            $display("logistic_gradient_hessian_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lgh_pkg.sv
rtl/lgh_sigmoid.sv
rtl/lgh_grad_hess.sv
rtl/logistic_gradient_hessian_unit.sv
verif/logistic_gradient_hessian_unit_tb.sv
